FILE: hw/rtl/b64_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 decoder.
`default_nettype none
package b64_pkg;

    localparam int CHAR_W     = 8;
    localparam int SEXTET_W   = 6;
    localparam int WORD_W     = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;    // no valid characters
    localparam logic [1:0] ST_COUNT = 2'd2;    // count not a multiple of four
    localparam logic [1:0] ST_PAD   = 2'd3;    // three or more pads in a group

    // Work handed from the front end to the output side.
    typedef struct packed {
        logic [WORD_W-1:0] word;        // decoded group, first byte high
        logic [1:0]        emit;        // data bytes to send (0..3)
        logic              has_status;  // a status beat follows the bytes
        logic [1:0]        status;
    } t_job;

    // {is_valid, sextet}; '=' is valid with value zero.
    function automatic logic [SEXTET_W:0] sextet_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = '0;
            if (c >= 8'h41 && c <= 8'h5A) begin
                d = c - 8'h41;
                sextet_of = {1'b1, d[SEXTET_W-1:0]};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                d = c - 8'h61 + 8'd26;
                sextet_of = {1'b1, d[SEXTET_W-1:0]};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30 + 8'd52;
                sextet_of = {1'b1, d[SEXTET_W-1:0]};
            end else if (c == 8'h2B) begin
                sextet_of = {1'b1, 6'd62};
            end else if (c == 8'h2F) begin
                sextet_of = {1'b1, 6'd63};
            end else if (c == PAD_CHAR) begin
                sextet_of = {1'b1, 6'd0};
            end else begin
                sextet_of = '0;
            end
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/base64_decoder_top.sv
// Top level of the streaming base64 decoder.
//
// Input channel: one character per beat (i_char_in, i_final_char), taken at
// an edge with i_valid high and o_stall low. Characters other than the base64
// alphabet and '=' are dropped. Every fourth valid character yields a group
// of three bytes, cut to two, one or none by pads; after a padded group no
// more bytes come out. The character flagged final adds one status beat
// (ok, no valid chars, bad count, too much padding); on an error status the
// receiver drops the bytes it already got. o_end_of_run marks the last beat
// caused by one character.
// Throughput: one character per cycle while the job queue has room; the
// output side sends one beat per cycle while i_stall is low, and a group of
// four characters yields at most four beats. From acceptance to the first
// beat, a job passes the queue, the queue head and the output registers.
// Reset (i_rst_n low, synchronous) clears the group state and empties the
// queue and output register. When the receiver holds i_stall, the output
// beat holds steady, the queue fills, and o_stall rises when it is full.
`default_nettype none
module base64_decoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_char_in,
    input  wire         i_final_char,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [1:0]  o_status,
    output logic        o_end_of_run
);
    import b64_pkg::*;

    logic  accept;
    logic  push, pop, full, job_valid;
    t_job  push_job, head_job;

    // Front end only ever stalls on a full queue.
    assign o_stall = full;
    assign accept  = i_valid && !full;

    b64_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_in    (i_char_in),
        .i_final_char (i_final_char),
        .o_push       (push),
        .o_job        (push_job)
    );

    b64_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    b64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_is_status  (o_is_status),
        .o_status     (o_status),
        .o_end_of_run (o_end_of_run)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/b64_front.sv
// Front end: classifies characters, assembles groups and builds output jobs.
`default_nettype none
module b64_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [7:0]           i_char_in,
    input  wire                 i_final_char,
    output logic                o_push,
    output b64_pkg::t_job       o_job
);
    import b64_pkg::*;

    logic [17:0] r_buf,   n_buf;
    logic [1:0]  r_gpos,  n_gpos;
    logic [2:0]  r_pads,  n_pads;
    logic [1:0]  r_vcnt,  n_vcnt;
    logic        r_seen,  n_seen;
    logic        r_stop,  n_stop;
    logic        r_perr,  n_perr;

    logic [SEXTET_W:0] lk;
    logic              is_valid;
    logic [2:0]        pads_new;
    logic              grp_done;
    logic [1:0]        emit;

    assign lk       = sextet_of(i_char_in);
    assign is_valid = lk[SEXTET_W];

    always_comb begin
        n_buf  = r_buf;
        n_gpos = r_gpos;
        n_pads = r_pads;
        n_vcnt = r_vcnt;
        n_seen = r_seen;
        n_stop = r_stop;
        n_perr = r_perr;
        grp_done = 1'b0;
        emit     = 2'd0;
        pads_new = r_pads;
        o_job.word       = {r_buf, lk[SEXTET_W-1:0]};
        o_job.has_status = i_final_char;
        o_job.status     = ST_OK;

        if (is_valid) begin
            n_seen = 1'b1;
            n_vcnt = r_vcnt + 2'd1;
            if (!r_stop) begin
                if (i_char_in == PAD_CHAR && r_pads < 3'd4)
                    pads_new = r_pads + 3'd1;
                if (r_gpos != 2'd3) begin
                    n_buf  = {r_buf[11:0], lk[SEXTET_W-1:0]};
                    n_gpos = r_gpos + 2'd1;
                    n_pads = pads_new;
                end else begin
                    grp_done = 1'b1;
                    case (pads_new)
                        3'd0:    emit = 2'd3;
                        3'd1:    emit = 2'd2;
                        3'd2:    emit = 2'd1;
                        default: begin
                            emit   = 2'd0;
                            n_perr = 1'b1;
                        end
                    endcase
                    if (pads_new != 3'd0)
                        n_stop = 1'b1;
                    n_buf  = '0;
                    n_gpos = 2'd0;
                    n_pads = 3'd0;
                end
            end
        end

        if (!n_seen)
            o_job.status = ST_EMPTY;
        else if (n_vcnt != 2'd0)
            o_job.status = ST_COUNT;
        else if (n_perr)
            o_job.status = ST_PAD;

        o_job.emit = emit;
        o_push     = i_accept && ((grp_done && emit != 2'd0) || i_final_char);

        // Final character: start the next text from scratch.
        if (i_final_char) begin
            n_buf  = '0;
            n_gpos = 2'd0;
            n_pads = 3'd0;
            n_vcnt = 2'd0;
            n_seen = 1'b0;
            n_stop = 1'b0;
            n_perr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_gpos <= 2'd0;
            r_pads <= 3'd0;
            r_vcnt <= 2'd0;
            r_seen <= 1'b0;
            r_stop <= 1'b0;
            r_perr <= 1'b0;
        end else if (i_accept) begin
            r_buf  <= n_buf;
            r_gpos <= n_gpos;
            r_pads <= n_pads;
            r_vcnt <= n_vcnt;
            r_seen <= n_seen;
            r_stop <= n_stop;
            r_perr <= n_perr;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/b64_fifo.sv
// Small job queue between the front end and the output side.
`default_nettype none
module b64_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  b64_pkg::t_job       i_job,
    input  wire                 i_pop,
    output logic                o_full,
    output logic                o_valid,
    output b64_pkg::t_job       o_job
);
    import b64_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    t_job               r_head;     // entry taken by the last pop
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_head;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_job;
        if (do_pop)
            r_head <= r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= r_wr + FIFO_AW'(1);
            if (do_pop)
                r_rd <= r_rd + FIFO_AW'(1);
            if (do_push && !do_pop)
                r_cnt <= r_cnt + (FIFO_AW+1)'(1);
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - (FIFO_AW+1)'(1);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/b64_back.sv
// Output side: unrolls each job into byte and status beats.
`default_nettype none
module b64_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    input  b64_pkg::t_job       i_job,      // job taken at the last pop
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_is_status,
    output logic [1:0]          o_status,
    output logic                o_end_of_run
);
    import b64_pkg::*;

    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_is_st;
    logic [1:0] r_st;
    logic       r_eor;

    logic       load_out, emit_now, cur_last, cur_st;
    logic [2:0] total_m1;
    logic [7:0] sel_byte;

    assign load_out = !r_out_valid || !i_stall;
    assign emit_now = r_busy && load_out;
    assign total_m1 = {1'b0, i_job.emit} + {2'b00, i_job.has_status} - 3'd1;
    assign cur_last = (r_idx == total_m1[1:0]);
    assign cur_st   = (r_idx >= i_job.emit);
    assign o_pop    = i_job_valid && (!r_busy || (emit_now && cur_last));

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_job.word[23:16];
            2'd1:    sel_byte = i_job.word[15:8];
            2'd2:    sel_byte = i_job.word[7:0];
            default: sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out)
                r_out_valid <= r_busy;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (emit_now) begin
                if (cur_last)
                    r_busy <= 1'b0;
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_byte  <= cur_st ? 8'd0 : sel_byte;
            r_is_st <= cur_st;
            r_st    <= cur_st ? i_job.status : ST_OK;
            r_eor   <= cur_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_byte;
    assign o_is_status  = r_is_st;
    assign o_status     = r_st;
    assign o_end_of_run = r_eor;

endmodule
`default_nettype wire
